FILE: rtl/kmh_pkg.sv
// kmh_pkg: shared types and codes of the k-ary max heap queue.
// Used by kmh_ctrl and kary_max_heap_queue; depends on nothing.
`default_nettype none

package kmh_pkg;

  // Width of the arity configuration register.
  localparam int ARITY_W = 4;
  localparam int KEY_W   = 32;

  // Request codes carried on req_type.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_DIV,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD0,
    S_EX_RD1,
    S_EX_LAST,
    S_DN_BASE,
    S_DN_SCAN,
    S_DN_DEC,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/kary_max_heap_queue.sv
// kary_max_heap_queue: top level of the k-ary max heap priority queue.
// Holds the arity register and instantiates kmh_ctrl; depends on kmh_pkg.
`default_nettype none

// Max priority queue of signed 32-bit keys kept as a k-ary heap in one
// synchronous memory. A request word (req_type, key_in) is taken when start
// is high and busy is low; exactly one result word (key_out, status, count)
// follows, shown for one cycle with done high. The receiver cannot stall, so
// it must capture the result in that cycle. Requests run one at a time and
// take a number of cycles set by the sift walk through the memory's single
// read port. An insert reads the parent at each level climbed and stops at
// the root or below a parent that is not smaller than the key; an extract
// that removes the last key just returns the root, any other extract also
// moves the last key to the root and sifts it down, reading the children
// of each node visited (each child key is read in its own cycle and
// compared as it returns). Errors (insert into a full heap, extract from an
// empty one) go straight to the result and leave the heap unchanged. Busy
// drops in the cycle that shows the result, so the next request can be
// taken there. The arity register (reset 2) may only be written while the
// block is idle; values below 2 act as 2 and values above MAX_ARITY act as
// MAX_ARITY. The key memory is not cleared at reset; only entries written
// by earlier inserts are ever read.
module kary_max_heap_queue
  import kmh_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int MAX_ARITY = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              req_type,
  input  wire logic signed [KEY_W-1:0]           key_in,
  input  wire logic                              cfg_we,
  input  wire logic [ARITY_W-1:0]                cfg_data,
  output logic                                   done,
  output logic signed [KEY_W-1:0]                key_out,
  output logic [1:0]                             status,
  output logic [$clog2(CAPACITY + 1)-1:0]        count
);

  localparam int KW = $clog2(MAX_ARITY + 1);

  // The arity register keeps the raw word written; the controller sees
  // the clamped value.
  logic [ARITY_W-1:0] arity;
  logic [KW-1:0]      k_eff;
  status_t            res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      arity <= ARITY_W'(2);
    end else if (cfg_we) begin
      arity <= cfg_data;
    end
  end

  // Clamp the arity into the supported range.
  always_comb begin
    if (arity < ARITY_W'(2)) begin
      k_eff = KW'(2);
    end else if (32'(arity) > MAX_ARITY) begin
      k_eff = KW'(MAX_ARITY);
    end else begin
      k_eff = KW'(arity);
    end
  end

  kmh_ctrl #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .k       (k_eff),
    .start   (start),
    .req     (req_type),
    .key_in  (key_in),
    .busy    (busy),
    .done    (done),
    .key_out (key_out),
    .status  (res_status),
    .count   (count)
  );

  assign status = res_status;

endmodule

`default_nettype wire

FILE: rtl/kmh_store.sv
// kmh_store: single-write, single-read synchronous key memory.
// The read data is registered and appears in the cycle after the read request. No dependencies.
`default_nettype none

module kmh_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kmh_ctrl.sv
// kmh_ctrl: sift sequencer of the heap queue, owns the key memory and the count.
// Depends on kmh_pkg and kmh_store.
`default_nettype none

module kmh_ctrl
  import kmh_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int MAX_ARITY = 8,
  parameter int IW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW        = $clog2(CAPACITY + 1),
  parameter int KW        = $clog2(MAX_ARITY + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [KW-1:0]           k,
  input  wire logic                    start,
  input  wire logic                    req,
  input  wire logic signed [KEY_W-1:0] key_in,
  output logic                         busy,
  output logic                         done,
  output logic signed [KEY_W-1:0]      key_out,
  output status_t                      status,
  output logic [CW-1:0]                count
);

  localparam int CHW = IW + KW;
  localparam int PW  = 2 * IW + 2;

  state_t state, state_next;

  logic [CW-1:0]           cnt;
  logic [IW-1:0]           pos;
  logic [IW-1:0]           parent;
  logic signed [KEY_W-1:0] key_reg;
  logic signed [KEY_W-1:0] root_key;
  status_t                 stat;
  logic [CHW-1:0]          child;
  logic [KW-1:0]           scan_i;
  logic                    pend;
  logic [IW-1:0]           pend_idx;
  logic signed [KEY_W-1:0] best_key;
  logic [IW-1:0]           best_idx;
  logic                    found;

  logic                    rd_en;
  logic [IW-1:0]           rd_addr;
  logic signed [KEY_W-1:0] rd_data;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  logic accept;
  logic issue;
  logic up_move;
  logic dn_move;
  logic take_child;

  logic [IW-1:0] pm1;
  logic [IW-1:0] quot [2:MAX_ARITY];

  kmh_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IW),
    .DATA_W (KEY_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Parent index (pos - 1) / k: one constant reciprocal multiply per arity,
  // selected by k. With a shift of IW + clog2(D) and the rounded-up
  // reciprocal, the quotient is exact for every IW-bit dividend.
  assign pm1 = pos - IW'(1);
  for (genvar D = 2; D <= MAX_ARITY; D++) begin : g_div
    localparam int SH  = IW + $clog2(D);
    localparam int RCP = ((1 << SH) + D - 1) / D;
    logic [PW-1:0] prod;
    assign prod    = PW'(pm1) * PW'(RCP);
    assign quot[D] = IW'(prod >> SH);
  end

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign issue      = (scan_i < k) && (child < CHW'(cnt));
  assign up_move    = key_reg > rd_data;
  assign dn_move    = found && (key_reg < best_key);
  assign take_child = pend && (!found || (rd_data > best_key));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req == REQ_INSERT) begin
            state_next = (cnt == CW'(CAPACITY)) ? S_FINISH : S_UP_DIV;
          end else begin
            state_next = (cnt == '0) ? S_FINISH : S_EX_RD0;
          end
        end
      end
      S_UP_DIV:  state_next = (pos == '0) ? S_FINISH : S_UP_RD;
      S_UP_RD:   state_next = S_UP_CMP;
      S_UP_CMP:  state_next = up_move ? S_UP_DIV : S_FINISH;
      S_EX_RD0:  state_next = S_EX_RD1;
      S_EX_RD1:  state_next = S_EX_LAST;
      S_EX_LAST: state_next = (cnt == CW'(1)) ? S_FINISH : S_DN_BASE;
      S_DN_BASE: state_next = S_DN_SCAN;
      S_DN_SCAN: state_next = (!issue && !pend) ? S_DN_DEC : S_DN_SCAN;
      S_DN_DEC:  state_next = dn_move ? S_DN_BASE : S_FINISH;
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = key_reg;
    unique case (state)
      S_UP_DIV: begin
        wr_en = (pos == '0);
      end
      S_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_move ? rd_data : key_reg;
      end
      S_EX_RD0: begin
        rd_en = 1'b1;
      end
      S_EX_RD1: begin
        rd_en   = 1'b1;
        rd_addr = IW'(cnt - CW'(1));
      end
      S_DN_SCAN: begin
        rd_en   = issue;
        rd_addr = child[IW-1:0];
      end
      S_DN_DEC: begin
        wr_en   = 1'b1;
        wr_data = dn_move ? best_key : key_reg;
      end
      S_IDLE, S_EX_LAST, S_DN_BASE, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      if (state == S_IDLE && accept) begin
        if (req == REQ_INSERT && cnt != CW'(CAPACITY)) begin
          cnt <= cnt + CW'(1);
        end
      end else if (state == S_EX_LAST) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          root_key <= '0;
          stat     <= ST_OK;
          key_reg  <= key_in;
          pos      <= cnt[IW-1:0];
          if (req == REQ_INSERT && cnt == CW'(CAPACITY)) begin
            stat <= ST_FULL;
          end else if (req == REQ_EXTRACT && cnt == '0) begin
            stat <= ST_EMPTY;
          end
        end
      end
      S_UP_DIV: begin
        parent <= quot[k];
      end
      S_UP_CMP: begin
        if (up_move) begin
          pos <= parent;
        end
      end
      S_EX_RD1: begin
        root_key <= rd_data;
      end
      S_EX_LAST: begin
        key_reg <= rd_data;
        pos     <= '0;
      end
      S_DN_BASE: begin
        child  <= CHW'(k) * CHW'(pos) + CHW'(1);
        scan_i <= '0;
        pend   <= 1'b0;
        found  <= 1'b0;
      end
      S_DN_SCAN: begin
        if (take_child) begin
          best_key <= rd_data;
          best_idx <= pend_idx;
          found    <= 1'b1;
        end
        pend <= issue;
        if (issue) begin
          pend_idx <= child[IW-1:0];
          child    <= child + CHW'(1);
          scan_i   <= scan_i + KW'(1);
        end
      end
      S_DN_DEC: begin
        if (dn_move) begin
          pos <= best_idx;
        end
      end
      S_FINISH: begin
        key_out <= root_key;
        status  <= stat;
        count   <= cnt;
      end
      S_UP_RD, S_EX_RD0: begin
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < cnt))
    else $error("heap write outside the occupied range");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CW'(rd_addr) < cnt))
    else $error("heap read outside the occupied range");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status reported with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == '0))
    else $error("empty status reported with keys held");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req == REQ_INSERT && cnt != CW'(CAPACITY)) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not grow the count by one");
`endif

endmodule

`default_nettype wire

FILE: tb/kmh_checker.sv
`timescale 1ns / 1ps
// kmh_checker: watches the request, result and arity-write channels of the
// k-ary max heap queue, predicts each result word and compares it field by field.
// Depends on kmh_pkg for key and arity widths, request codes and status codes.

module kmh_checker
  import kmh_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int MAX_ARITY = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               req_type,
  input  logic signed [KEY_W-1:0]            key_in,
  input  logic                               cfg_we,
  input  logic [ARITY_W-1:0]                 cfg_data,
  input  logic                               done,
  input  logic signed [KEY_W-1:0]            key_out,
  input  logic [1:0]                         status,
  input  logic [$clog2(CAPACITY + 1)-1:0]    count,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef struct {
    logic signed [KEY_W-1:0] key;
    status_t                 status;
    logic [CNT_W-1:0]        count;
  } heap_reply_t;

  // Shadow copy of the heap, its fill level and the raw arity register.
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned             held;
  logic [ARITY_W-1:0]      arity_reg;
  heap_reply_t             replies_due [$];

  // Out-of-range arity values are clamped, the register keeps the raw value.
  function automatic int unsigned fanout();
    if (arity_reg < 2) return 2;
    if (arity_reg > MAX_ARITY) return MAX_ARITY;
    return arity_reg;
  endfunction

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [KEY_W-1:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Applies one request to the shadow heap and returns the word it must produce.
  function automatic heap_reply_t serve_request(logic req, logic signed [KEY_W-1:0] key);
    heap_reply_t r;
    int unsigned k, pos, parent, best, c, i;
    bit found;
    k = fanout();
    r.key = '0;
    r.status = ST_OK;
    if (req == REQ_INSERT) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[held] = key;
        pos = held;
        held++;
        while (pos > 0) begin
          parent = (pos - 1) / k;
          if (heap_keys[pos] > heap_keys[parent]) begin
            swap_keys(pos, parent);
            pos = parent;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = heap_keys[0];
        heap_keys[0] = heap_keys[held - 1];
        held--;
        pos = 0;
        while (pos < held) begin
          found = 1'b0;
          best = 0;
          // Strict compare keeps the lowest-index child among equal maxima.
          for (i = 1; i <= k; i++) begin
            c = k * pos + i;
            if (c < held && (!found || heap_keys[c] > heap_keys[best])) begin
              best = c;
              found = 1'b1;
            end
          end
          if (!found || !(heap_keys[pos] < heap_keys[best])) break;
          swap_keys(pos, best);
          pos = best;
        end
      end
    end
    r.count = held[CNT_W-1:0];
    return r;
  endfunction

  // A result of the previous word is retired before a new word is taken, since
  // the block may show a result in the same cycle that it accepts the next word.
  always @(posedge clk) begin
    heap_reply_t want;
    if (rst) begin
      held = 0;
      arity_reg = 2;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word: key %0d status %0d count %0d",
                   $time, key_out, status, count);
        end else begin
          want = replies_due.pop_front();
          if (key_out !== want.key || status !== want.status || count !== want.count) begin
            fail_count++;
            $display("%0t: result mismatch: expected key %0d status %0d count %0d, got key %0d status %0d count %0d",
                     $time, want.key, want.status, want.count, key_out, status, count);
          end
        end
      end
      if (start && !busy) replies_due.push_back(serve_request(req_type, key_in));
      if (cfg_we) arity_reg = cfg_data;
    end
    pending = replies_due.size();
  end

endmodule

FILE: tb/tb_kary_max_heap_queue.sv
`timescale 1ns / 1ps
// tb_kary_max_heap_queue: testbench top for the k-ary max heap queue.
// Drives request words and arity writes; kmh_checker (with kmh_pkg) does the checking.

module tb_kary_max_heap_queue;
  import kmh_pkg::*;

  localparam int CAPACITY  = 1024;
  localparam int MAX_ARITY = 8;
  localparam int LIMIT     = 1_000_000;

  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              start    = 1'b0;
  logic                              req_type = REQ_INSERT;
  logic signed [KEY_W-1:0]           key_in   = '0;
  logic                              cfg_we   = 1'b0;
  logic [ARITY_W-1:0]                cfg_data = '0;
  logic                              busy;
  logic                              done;
  logic signed [KEY_W-1:0]           key_out;
  logic [1:0]                        status;
  logic [$clog2(CAPACITY + 1)-1:0]   count;
  int                                fail_count;
  int                                pending;
  int unsigned                       cycles = 0;

  // Arity values per random phase: in-range values, both clamp directions and
  // the all-zero and all-one register patterns.
  logic [ARITY_W-1:0] arity_plan [9] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7};
  // Sender idle percentage per phase. The receiver cannot stall, so the phase
  // meant for receiver stalls runs without idling.
  int unsigned idle_plan [4] = '{0, 80, 0, 6};

  always #1 clk = ~clk;

  kary_max_heap_queue #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .key_in   (key_in),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .key_out  (key_out),
    .status   (status),
    .count    (count)
  );

  kmh_checker #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) heap_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .key_in     (key_in),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .key_out    (key_out),
    .status     (status),
    .count      (count),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one request word and returns at the falling edge after it was
  // taken. Start is left high so a back-to-back word needs no second assignment
  // in the same step; an idle cycle or the end of a phase lowers it.
  task automatic send_word(input logic req, input logic signed [KEY_W-1:0] key,
                           input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    req_type <= req;
    key_in   <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted word has come back and the block is idle, and
  // only then lets the arity register be touched.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_arity(input logic [ARITY_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Key mix: mostly full-range values, plus a narrow band that forces equal
  // keys and values at or near both ends of the signed range.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      5, 6:    return $signed($urandom_range(15)) - 8;
      7: begin
        case ($urandom_range(3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      8:       return 32'sh7FFF_FFFF - $urandom_range(3);
      9:       return 32'sh8000_0000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Random words with a given share of inserts, so a phase can grow or shrink
  // the heap. Extract words carry random keys too, which the block must ignore.
  task automatic random_run(input int unsigned n, input int unsigned insert_pct,
                            input int unsigned idle_pct);
    repeat (n) begin
      send_word(($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_EXTRACT,
                pick_key(), idle_pct);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset arity of two: an extract from the empty heap,
    // both ends of the key range, zero and minus one, a run of equal keys, then
    // a full drain that must come out in descending order and one more extract
    // from the empty heap with a nonzero key that has to be ignored.
    send_word(REQ_EXTRACT, 32'sd0, 0);
    send_word(REQ_INSERT, 32'sh7FFF_FFFF, 0);
    send_word(REQ_INSERT, 32'sh8000_0000, 0);
    send_word(REQ_INSERT, 32'sd0, 0);
    send_word(REQ_INSERT, -32'sd1, 0);
    send_word(REQ_INSERT, 32'sd5, 0);
    send_word(REQ_INSERT, 32'sd5, 0);
    send_word(REQ_INSERT, 32'sd5, 0);
    send_word(REQ_INSERT, 32'sd1, 0);
    repeat (8) send_word(REQ_EXTRACT, 32'sh5A5A_A5A5, 0);
    send_word(REQ_EXTRACT, 32'shA5A5_5A5A, 0);

    // Random phases, each under its own arity. The heap is carried over from
    // one phase to the next, so a new arity also meets a heap built under the
    // old one.
    foreach (arity_plan[i]) begin
      settle();
      set_arity(arity_plan[i]);
      random_run(50, 70, idle_plan[i % 4]);
      random_run(30, 35, idle_plan[i % 4]);
    end

    // Drain the heap under the narrowest tree in bursts of extracts until the
    // last result reports it empty; the tail of the final burst may hit the
    // empty heap.
    settle();
    set_arity(4'd2);
    do begin
      repeat (16) send_word(REQ_EXTRACT, pick_key(), 0);
      settle();
    end while (count != '0);

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
